@@ rtl/core/mclp_pkg.sv @@
package mclp_pkg;

  localparam int LINE_BYTES_DEF = 64;
  localparam logic [6:0] MAX_SPEED_RST = 7'd100;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_V_LO  = 8'h76;
  localparam logic [7:0] CH_V_UP  = 8'h56;
  localparam logic [7:0] CH_D_LO  = 8'h64;
  localparam logic [7:0] CH_D_UP  = 8'h44;

  localparam logic [1:0] MOTOR_NONE = 2'd0;
  localparam logic [1:0] MOTOR_ONE  = 2'd1;
  localparam logic [1:0] MOTOR_TWO  = 2'd2;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } num_phase_t;

  typedef enum logic [1:0] {
    ST_IGNORED,
    ST_SPEED,
    ST_DIR,
    ST_ERROR
  } status_t;

  typedef struct packed {
    num_phase_t  phase;
    logic        negative;
    logic [7:0]  magnitude;
  } num_state_t;

  typedef struct packed {
    logic        start_kick;
    logic        direction;
    logic [6:0]  speed_value;
    logic [1:0]  motor_select;
    status_t     status;
  } result_t;

endpackage

@@ rtl/core/mclp_num_step.sv @@
module mclp_num_step
  import mclp_pkg::*;
(
  input  logic       en,
  input  logic [7:0] rx_byte,
  input  num_state_t cur,
  output num_state_t nxt
);

  logic        is_digit;
  logic        is_space;
  logic [11:0] acc;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  // magnitude * 10 + digit, at most 2559
  assign acc = ({4'd0, cur.magnitude} << 3) + ({4'd0, cur.magnitude} << 1)
             + {4'd0, rx_byte - CH_ZERO};

  always_comb begin
    nxt = cur;
    if (en && (cur.phase != PH_DONE)) begin
      if (is_digit) begin
        nxt.magnitude = (acc > 12'd255) ? 8'd255 : acc[7:0];
        nxt.phase     = PH_DIGITS;
      end else if ((cur.phase == PH_SKIP) && is_space) begin
        nxt.phase = PH_SKIP;
      end else if ((cur.phase == PH_SKIP) && ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS))) begin
        nxt.negative = (rx_byte == CH_MINUS);
        nxt.phase    = PH_SIGN;
      end else begin
        nxt.phase = PH_DONE;
      end
    end
  end

endmodule

@@ rtl/core/motor_command_line_parser.sv @@
// Motor command line parser. Takes one received character per in_ word every
// cycle while in_tready is high and keeps the first four characters of the line
// plus a running decimal parse of the number from the third character on. A
// line feed closes the line and gives exactly one registered out_ word; other
// characters give none. Accepted commands are "v1 N"/"v2 N" (speed, 0 to
// max_speed, optional whitespace and sign before N) and "d1 c"/"d2 c"
// (direction, c is 0 forward or 1 reverse); 'V' and 'D' work too. A wrong
// command letter or a bad value reports an error; a bad motor digit or a
// missing space reports ignored. start_kick marks the first nonzero speed for a
// motor after reset or after a zero speed. Characters past LINE_BYTES are
// dropped but the line feed still closes the line. The result side has an
// output register and one skid word, so in_tready falls only when two results
// are waiting on a stalled out_ side. max_speed resets to 100; the user must
// write it via cfg_wr_en/cfg_wr_data while the parser is idle (not enforced).
module motor_command_line_parser
  import mclp_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [1:0] status, [3:2] motor_select,
                                   // [10:4] speed_value, [11] direction,
                                   // [12] start_kick, [15:13] zero
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  localparam int PW = $clog2(LINE_BYTES + 1);

  logic [6:0]    max_speed_r;
  logic [PW-1:0] pos_r;
  logic [7:0]    cmd_r, motor_r, sep_r, dir_r;
  num_state_t    num_r, num_nxt;
  logic [1:0]    flags_r, flags_nxt;

  logic [7:0]    cmd_nxt, motor_nxt, sep_nxt, dir_nxt;
  logic          acc_in, is_lf, cap_en;
  result_t       res;

  result_t       out_r, skid_r;
  logic          out_valid_r, skid_valid_r;
  logic          new_res;

  assign acc_in = in_tvalid && in_tready;
  assign is_lf  = (in_tdata == CH_LF);
  assign cap_en = (pos_r < PW'(LINE_BYTES));

  assign cmd_nxt   = (cap_en && (pos_r == PW'(0))) ? in_tdata : cmd_r;
  assign motor_nxt = (cap_en && (pos_r == PW'(1))) ? in_tdata : motor_r;
  assign sep_nxt   = (cap_en && (pos_r == PW'(2))) ? in_tdata : sep_r;
  assign dir_nxt   = (cap_en && (pos_r == PW'(3))) ? in_tdata : dir_r;

  mclp_num_step u_num (
    .en      (cap_en && (pos_r >= PW'(2))),
    .rx_byte (in_tdata),
    .cur     (num_r),
    .nxt     (num_nxt)
  );

  // line-end decision on the capture including the line feed itself
  always_comb begin
    logic is_speed, is_dir, motor_ok, two, bad;
    is_speed  = (cmd_nxt == CH_V_LO) || (cmd_nxt == CH_V_UP);
    is_dir    = (cmd_nxt == CH_D_LO) || (cmd_nxt == CH_D_UP);
    two       = (motor_nxt == CH_TWO);
    motor_ok  = ((motor_nxt == CH_ONE) || two) && (sep_nxt == CH_SPACE);
    bad       = (num_nxt.negative && (num_nxt.magnitude != 8'd0))
              || (num_nxt.magnitude > {1'b0, max_speed_r});
    res       = '0;
    flags_nxt = flags_r;
    if (!is_speed && !is_dir) begin
      res.status = ST_ERROR;
    end else if (motor_ok) begin
      if (is_speed) begin
        if (bad) begin
          res.status = ST_ERROR;
        end else begin
          res.status       = ST_SPEED;
          res.motor_select = two ? MOTOR_TWO : MOTOR_ONE;
          res.speed_value  = num_nxt.magnitude[6:0];
          if (num_nxt.magnitude == 8'd0) begin
            flags_nxt[two] = 1'b1;
          end else if (flags_r[two]) begin
            flags_nxt[two] = 1'b0;
            res.start_kick = 1'b1;
          end
        end
      end else if ((dir_nxt == CH_ZERO) || (dir_nxt == CH_ONE)) begin
        res.status       = ST_DIR;
        res.motor_select = two ? MOTOR_TWO : MOTOR_ONE;
        res.direction    = (dir_nxt == CH_ONE);
      end else begin
        res.status = ST_ERROR;
      end
    end
  end

  assign new_res = acc_in && is_lf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= MAX_SPEED_RST;
      pos_r       <= '0;
      cmd_r       <= '0;
      motor_r     <= '0;
      sep_r       <= '0;
      dir_r       <= '0;
      num_r       <= '{phase: PH_SKIP, negative: 1'b0, magnitude: 8'd0};
      flags_r     <= 2'b11;
    end else begin
      if (cfg_wr_en) begin
        max_speed_r <= cfg_wr_data;
      end
      if (acc_in) begin
        if (is_lf) begin
          // clear the capture on every line feed
          pos_r   <= '0;
          cmd_r   <= '0;
          motor_r <= '0;
          sep_r   <= '0;
          dir_r   <= '0;
          num_r   <= '{phase: PH_SKIP, negative: 1'b0, magnitude: 8'd0};
          flags_r <= flags_nxt;
        end else begin
          cmd_r   <= cmd_nxt;
          motor_r <= motor_nxt;
          sep_r   <= sep_nxt;
          dir_r   <= dir_nxt;
          num_r   <= num_nxt;
          if (cap_en) begin
            pos_r <= pos_r + PW'(1);
          end
        end
      end
    end
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_tready) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end else if (new_res) begin
        out_r <= res;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (!out_valid_r) begin
      if (new_res) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end
    end else if (new_res) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  assign in_tready  = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.start_kick, out_r.direction, out_r.speed_value,
                       out_r.motor_select, out_r.status};

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid word held with empty output register");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(LINE_BYTES)) else $error("line position past line length");

  a_lf_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata == CH_LF)) |=> (pos_r == PW'(0)))
    else $error("capture not cleared after line feed");

  a_kick_only_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.start_kick) |->
      ((out_r.status == ST_SPEED) && (out_r.speed_value != 7'd0)))
    else $error("start kick without nonzero speed");

  a_no_action_no_motor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_r.status == ST_IGNORED) || (out_r.status == ST_ERROR))) |->
      ((out_r.motor_select == MOTOR_NONE) && (out_r.speed_value == 7'd0)))
    else $error("motor reported on ignored or failed command");
`endif

endmodule

@@ tb/mclp_line_checker.sv @@
`timescale 1ns / 1ps
module mclp_line_checker
  import mclp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,   // [1:0] status, [3:2] motor_select,
                                   // [10:4] speed_value, [11] direction,
                                   // [12] start_kick, [15:13] zero
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  output int          errors,
  output int          pending
);

  logic [6:0] speed_limit;
  int         line_pos;
  logic [7:0] cmd_char;
  logic [7:0] motor_char;
  logic [7:0] sep_char;
  logic [7:0] dir_char;
  num_phase_t num_phase;
  logic       num_negative;
  logic [7:0] num_magnitude;
  logic [1:0] start_armed;     // first-start flag per motor, bit 0 is motor 1
  result_t    expected_words[$];
  result_t    got;
  result_t    want;
  result_t    closed;

  task clear_line();
    line_pos      = 0;
    cmd_char      = '0;
    motor_char    = '0;
    sep_char      = '0;
    dir_char      = '0;
    num_phase     = PH_SKIP;
    num_negative  = 1'b0;
    num_magnitude = '0;
  endtask

  task feed_number(input logic [7:0] c);
    int acc;
    if (num_phase != PH_DONE) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        acc = int'(num_magnitude) * 10 + int'(c) - int'(CH_ZERO);
        num_magnitude = (acc > 255) ? 8'd255 : 8'(acc);
        num_phase = PH_DIGITS;
      end else if (num_phase == PH_SKIP && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
        // skip leading whitespace
      end else if (num_phase == PH_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
        num_negative = (c == CH_MINUS);
        num_phase = PH_SIGN;
      end else begin
        num_phase = PH_DONE;
      end
    end
  endtask

  task take_char(input logic [7:0] c);
    // drop everything past the capture length
    if (line_pos < LINE_BYTES_DEF) begin
      case (line_pos)
        0: cmd_char = c;
        1: motor_char = c;
        2: sep_char = c;
        3: dir_char = c;
        default: ;
      endcase
      if (line_pos >= 2) feed_number(c);
      line_pos++;
    end
  endtask

  task close_line(output result_t r);
    logic       is_speed;
    logic       is_dir;
    logic       motor_ok;
    logic [1:0] m;
    r = '0;
    r.status = ST_IGNORED;
    is_speed = (cmd_char == CH_V_LO) || (cmd_char == CH_V_UP);
    is_dir   = (cmd_char == CH_D_LO) || (cmd_char == CH_D_UP);
    motor_ok = ((motor_char == CH_ONE) || (motor_char == CH_TWO)) && (sep_char == CH_SPACE);
    m = (motor_char == CH_ONE) ? MOTOR_ONE : MOTOR_TWO;
    if (!is_speed && !is_dir) begin
      r.status = ST_ERROR;
    end else if (motor_ok && is_speed) begin
      if ((num_negative && num_magnitude != 0) || (num_magnitude > {1'b0, speed_limit})) begin
        r.status = ST_ERROR;
      end else begin
        r.status       = ST_SPEED;
        r.motor_select = m;
        r.speed_value  = num_magnitude[6:0];
        if (num_magnitude == 0) begin
          start_armed[m - 1] = 1'b1;
        end else if (start_armed[m - 1]) begin
          start_armed[m - 1] = 1'b0;
          r.start_kick = 1'b1;
        end
      end
    end else if (motor_ok) begin
      if (dir_char == CH_ZERO || dir_char == CH_ONE) begin
        r.status       = ST_DIR;
        r.motor_select = m;
        r.direction    = (dir_char == CH_ONE);
      end else begin
        r.status = ST_ERROR;
      end
    end
    clear_line();
  endtask

  task report_mismatch(input string what, input int got_v, input int want_v);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got_v, want_v);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      speed_limit = MAX_SPEED_RST;
      start_armed = 2'b11;
      clear_line();
      expected_words.delete();
    end else begin
      if (cfg_wr_en) speed_limit = cfg_wr_data;
      // retire the output word before a new line closes at the same edge
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[12:0]);
        if (out_tdata[15:13] != 3'b000)
          report_mismatch("padding bits", int'(out_tdata[15:13]), 0);
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing expected", int'(out_tdata), 0);
        end else begin
          want = expected_words.pop_front();
          if (got.status != want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
          if (got.motor_select != want.motor_select)
            report_mismatch("motor_select", int'(got.motor_select),
                            int'(want.motor_select));
          if (got.speed_value != want.speed_value)
            report_mismatch("speed_value", int'(got.speed_value), int'(want.speed_value));
          if (got.direction != want.direction)
            report_mismatch("direction", int'(got.direction), int'(want.direction));
          if (got.start_kick != want.start_kick)
            report_mismatch("start_kick", int'(got.start_kick), int'(want.start_kick));
        end
      end
      if (in_tvalid && in_tready) begin
        take_char(in_tdata);
        if (in_tdata == CH_LF) begin
          close_line(closed);
          expected_words.push_back(closed);
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

@@ tb/tb_motor_command_line_parser.sv @@
`timescale 1ns / 1ps
module tb_motor_command_line_parser;
  import mclp_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_BYTES = 340;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [1:0] status, [3:2] motor_select,
                                 // [10:4] speed_value, [11] direction,
                                 // [12] start_kick, [15:13] zero
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;

  int         errors;
  int         pending;
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         max_setting = int'(MAX_SPEED_RST);
  int         bytes_sent = 0;
  int         quiet_cycles = 0;
  logic [7:0] line_buf[$];

  motor_command_line_parser i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  mclp_line_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    send_byte(CH_LF);
  endtask

  task send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_LF);
  endtask

  // hold the input until every expected word is out and the pipeline is quiet
  task wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task set_max_speed(input int v);
    wait_drained();
    cfg_wr_data <= 7'(v);
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    max_setting = v;
  endtask

  function automatic logic [7:0] any_char();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    return (b == CH_LF) ? (b ^ 8'h80) : b;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(4))
      0: return CH_TAB;
      1: return 8'd11;
      2: return 8'd12;
      3: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  task build_line();
    int         kind;
    int         roll;
    int         n;
    int         val;
    string      digits;
    logic [7:0] cmd;
    line_buf.delete();
    kind = $urandom_range(99);
    if (kind < 8) begin
      n = $urandom_range(8);
      repeat (n) line_buf.push_back(any_char());
    end else if (kind < 11) begin
      // long line, the tail usually falls past the capture
      if (kind == 10) begin
        line_buf.push_back(CH_V_LO);
        line_buf.push_back(CH_ONE);
        line_buf.push_back(CH_SPACE);
      end
      n = $urandom_range(60, 90);
      repeat (n)
        line_buf.push_back($urandom_range(1) ? CH_SPACE : 8'($urandom_range(CH_ZERO, CH_NINE)));
    end else begin
      roll = $urandom_range(99);
      if (roll < 30)      cmd = CH_V_LO;
      else if (roll < 45) cmd = CH_V_UP;
      else if (roll < 75) cmd = CH_D_LO;
      else if (roll < 90) cmd = CH_D_UP;
      else                cmd = any_char();
      line_buf.push_back(cmd);
      roll = $urandom_range(99);
      line_buf.push_back((roll < 45) ? CH_ONE : (roll < 90) ? CH_TWO : any_char());
      line_buf.push_back(($urandom_range(99) < 92) ? CH_SPACE : any_char());
      if (cmd == CH_D_LO || cmd == CH_D_UP) begin
        roll = $urandom_range(99);
        if (roll < 85)      line_buf.push_back($urandom_range(1) ? CH_ONE : CH_ZERO);
        else if (roll < 95) line_buf.push_back(any_char());
        if ($urandom_range(9) == 0) line_buf.push_back(any_char());
      end else begin
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) line_buf.push_back(blank_char());
        roll = $urandom_range(99);
        if (roll < 15)      line_buf.push_back(CH_PLUS);
        else if (roll < 30) line_buf.push_back(CH_MINUS);
        roll = $urandom_range(99);
        if (roll < 60)      val = $urandom_range(max_setting + 3);
        else if (roll < 70) val = 0;
        else if (roll < 90) val = $urandom_range(400);
        else                val = -1;
        if (val >= 0) begin
          if ($urandom_range(9) == 0) line_buf.push_back(CH_ZERO);
          digits = $sformatf("%0d", val);
          for (int i = 0; i < digits.len(); i++) line_buf.push_back(digits[i]);
        end
        if ($urandom_range(99) < 15) begin
          n = $urandom_range(1, 3);
          repeat (n) line_buf.push_back(any_char());
        end
      end
      // now and then cut the line short
      if ($urandom_range(19) == 0) begin
        n = $urandom_range(3);
        while (line_buf.size() > n) void'(line_buf.pop_back());
      end
    end
  endtask

  task run_random(input int count);
    int first;
    first = bytes_sent;
    while (bytes_sent - first < count) begin
      build_line();
      send_line();
    end
  endtask

  initial begin
    gap_pct   = 8;
    stall_pct = 86;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("v1 0");
    send_text("v1 5");
    send_text("v1 7");
    send_text("V2 +100");
    send_text("v2 101");
    send_text("v1 -0");
    send_text("v1 -3");
    send_text("v2 999");
    send_text("v1 \t 42abc");
    send_text("v1 ");
    send_text("d1 1");
    send_text("D2 0");
    send_text("d1 x");
    send_text("d1 ");
    send_text("v1");
    send_text("v3 5");
    send_text("v15");
    send_text("x1 5");
    send_text("");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CH_LF);
    // digits beyond the capture length are dropped, so this reads as zero
    line_buf.delete();
    line_buf.push_back(CH_V_LO);
    line_buf.push_back(CH_TWO);
    repeat (62) line_buf.push_back(CH_SPACE);
    line_buf.push_back(CH_NINE);
    line_buf.push_back(CH_NINE);
    send_line();

    set_max_speed(127);
    run_random(PHASE_BYTES);

    gap_pct   = 86;
    stall_pct = 8;
    set_max_speed(0);
    run_random(PHASE_BYTES);

    gap_pct   = 0;
    stall_pct = 0;
    set_max_speed($urandom_range(1, 126));
    run_random(PHASE_BYTES);

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
